// File: hw/rtl/bitmap_first_fit_allocator_core_assert.svh
// Assertion macros used by the checker.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication.
`define BFA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define BFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hw/rtl/bfa_pkg.sv
package bfa_pkg;

   localparam int MAX_BITS   = 8192;
   localparam int WORD_BITS  = 32;
   localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW    = $clog2(WORD_COUNT);
   localparam int POS_W      = $clog2(WORD_BITS);
   localparam int IDX_W      = 13;
   localparam int LEN_W      = 14;
   localparam int REM_W      = LEN_W + 1;

   localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_BITS);
   localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8192);

   typedef enum logic {
      ACT_ALLOC = 1'b0,
      ACT_FREE  = 1'b1
   } action_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_ALLOC = 2'd2,
      ST_RANGE     = 2'd3
   } status_type;

   typedef enum logic {
      S_IDLE = 1'b0,
      S_SCAN = 1'b1
   } state_type;

   typedef struct packed {
      action_type       action;
      logic [IDX_W-1:0] bit_index;
   } req_item_type;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] allocated_index;
   } rsp_item_type;

   // Result of examining one bitmap word.
   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] pos;
      logic             more;
   } scan_type;

endpackage

// File: hw/rtl/bfa_bitmap_mem.sv
module bfa_bitmap_mem
   import bfa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  logic [WORD_AW-1:0]   rd_addr,
   output logic [WORD_BITS-1:0] rd_data,
   input  logic                 wr_en,
   input  logic [WORD_AW-1:0]   wr_addr,
   input  logic [WORD_BITS-1:0] wr_data
);

   logic [WORD_BITS-1:0]  mem_ff [WORD_COUNT];
   logic [WORD_COUNT-1:0] valid_ff;
   logic [WORD_BITS-1:0]  rd_data_ff;

   // Never-written words read as all free.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/bfa_word_scan.sv
module bfa_word_scan
   import bfa_pkg::*;
(
   input  logic [WORD_BITS-1:0] word_data,
   input  logic [WORD_AW-1:0]   word_idx,
   input  logic [LEN_W-1:0]     len_eff,
   output scan_type             scan
);

   logic [REM_W-1:0]     remain;
   logic                 neg;
   logic                 all_valid;
   logic [WORD_BITS-1:0] valid_mask;
   logic [WORD_BITS-1:0] avail;

   // Bits left in the map from the start of this word.
   assign remain    = {1'b0, len_eff} - REM_W'({word_idx, {POS_W{1'b0}}});
   assign neg       = remain[REM_W-1];
   assign all_valid = !neg && (remain >= REM_W'(WORD_BITS));

   always_comb begin
      for (int p = 0; p < WORD_BITS; p++) begin
         valid_mask[p] = !neg && (all_valid || (POS_W'(p) < remain[POS_W-1:0]));
      end
   end

   assign avail = ~word_data & valid_mask;

   always_comb begin
      scan.pos = '0;
      for (int p = WORD_BITS - 1; p >= 0; p--) begin
         if (avail[p]) begin
            scan.pos = POS_W'(p);
         end
      end
      scan.found = |avail;
      scan.more  = !neg && (remain > REM_W'(WORD_BITS));
   end

endmodule

// File: hw/rtl/bitmap_first_fit_allocator_core.sv
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  req_item  (action, bit_index)
// rsp       out        rsp_valid/rsp_stall  rsp_item  (status, allocated_index)
// csr       in/out     APB psel/penable     bitmap_length at byte address 0
//
// Allocate: W = words examined from word 0, at most ceil(len/32) = 256;
//   one bitmap word read per cycle through the scan unit while scanning.
//   The next item is taken the cycle after the result loads.
// Free: one read, then check and write back.
// Reset: synchronous; per-word valid bits make the map read all free at once.
// A stalled result sits in the output register; the next item is accepted
//   meanwhile, and its result waits until the register frees.
module bitmap_first_fit_allocator_core
   import bfa_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   // result channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   // configuration port
   input  logic         psel,
   input  logic         penable,
   input  logic         pwrite,
   input  logic [1:0]   paddr,
   input  logic [31:0]  pwdata,
   output logic [31:0]  prdata,
   output logic         pready
);

   state_type            state_ff, state_in;
   logic [WORD_AW-1:0]   word_ff, word_in;
   action_type           act_ff, act_in;
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [LEN_W-1:0]     len_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_item_type         rsp_item_ff, rsp_item_in;

   logic                 rd_en;
   logic [WORD_AW-1:0]   rd_addr;
   logic [WORD_BITS-1:0] rd_data;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;
   logic [LEN_W-1:0]     len_eff;
   scan_type             scan;
   logic                 out_free;
   logic                 req_take;
   logic [WORD_BITS-1:0] bit_mask;

   // ---------------- configuration ----------------
   // Only one register: every address maps to bitmap_length.
   assign pready = 1'b1;
   assign prdata = 32'(len_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= LEN_RESET;
      end else if (psel && penable && pwrite) begin
         len_ff <= pwdata[LEN_W-1:0];
      end
   end

   // Lengths above the map size saturate.
   assign len_eff = (len_ff > MAX_LEN) ? MAX_LEN : len_ff;

   // ---------------- datapath ----------------
   bfa_bitmap_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (word_ff),
      .wr_data (wr_data)
   );

   bfa_word_scan u_scan (
      .word_data (rd_data),
      .word_idx  (word_ff),
      .len_eff   (len_eff),
      .scan      (scan)
   );

   // ---------------- sequencer ----------------
   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Bit mask: for free, the named index's bit within its word; for alloc, scan.pos.
   assign bit_mask = (act_ff == ACT_FREE) ? (WORD_BITS'(1) << idx_ff[POS_W-1:0])
                                          : (WORD_BITS'(1) << scan.pos);

   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      act_in       = act_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_item_in  = rsp_item_ff;
      rd_en        = 1'b0;
      rd_addr      = word_ff;
      wr_en        = 1'b0;
      wr_data      = rd_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               act_in   = req_item.action;
               idx_in   = req_item.bit_index;
               // Alloc starts at word 0; free reads the word holding the bit.
               word_in  = (req_item.action == ACT_FREE)
                          ? req_item.bit_index[IDX_W-1:POS_W] : '0;
               rd_en    = 1'b1;
               rd_addr  = word_in;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (act_ff == ACT_ALLOC) begin
               if (!scan.found && scan.more) begin
                  // Move on to the next word.
                  word_in = word_ff + WORD_AW'(1);
                  rd_en   = 1'b1;
                  rd_addr = word_in;
               end else if (out_free) begin
                  rsp_valid_in = 1'b1;
                  state_in     = S_IDLE;
                  if (scan.found) begin
                     wr_en                       = 1'b1;
                     wr_data                     = rd_data | bit_mask;
                     rsp_item_in.status          = ST_OK;
                     rsp_item_in.allocated_index = {word_ff, scan.pos};
                  end else begin
                     rsp_item_in.status          = ST_FULL;
                     rsp_item_in.allocated_index = '0;
                  end
               end
            end else if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_item_in.allocated_index = '0;
               state_in                    = S_IDLE;
               priority if ({1'b0, idx_ff} >= len_eff) begin
                  rsp_item_in.status = ST_RANGE;
               end else if ((rd_data & bit_mask) == '0) begin
                  rsp_item_in.status = ST_NOT_ALLOC;
               end else begin
                  wr_en              = 1'b1;
                  wr_data            = rd_data & ~bit_mask;
                  rsp_item_in.status = ST_OK;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      act_ff      <= act_in;
      idx_ff      <= idx_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// File: hw/rtl/bfa_checker.sv
`include "bitmap_first_fit_allocator_core_assert.svh"

module bfa_checker
   import bfa_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   // A stalled result holds.
   `BFA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
                    rsp_valid && $stable(rsp_item))

   // The block is busy right after taking an item.
   `BFA_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall, req_stall)

   // Only a successful allocation carries an index.
   `BFA_ASSERT_NOW(a_index_zero, clock, reset, rsp_valid && (rsp_item.status != ST_OK),
                   rsp_item.allocated_index == '0)

   // A new result follows a busy cycle.
   `BFA_ASSERT_NOW(a_rsp_after_work, clock, reset, $rose(rsp_valid), $past(req_stall))

endmodule

bind bitmap_first_fit_allocator_core bfa_checker u_bfa_checker (.*);
